// File: design/voxel_face_culling_mesher_defines.svh
// Assertion macros shared by the checkers of the voxel face mesher.
// Each expects clk and arst_n in the scope where it is used.
`ifndef VOXEL_FACE_CULLING_MESHER_DEFINES_SVH
`define VOXEL_FACE_CULLING_MESHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFCM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vfcm checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define VFCM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vfcm checker: property failed");

`endif

// File: design/vfcm_pkg.sv
package vfcm_pkg;

	localparam int CHUNK_EDGE = 16;
	localparam int CHUNK_W    = 6;
	localparam int LOCAL_W    = 4;
	localparam int POS_W      = 11;
	localparam int COLOUR_W   = 8;
	localparam int FACE_W     = 3;
	localparam int VNUM_W     = 17;
	localparam int NUM_FACES  = 6;
	localparam int CORNERS    = 4;
	localparam int CORNER_W   = $clog2(CORNERS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CHUNK_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHUNK_X = 2'd0,
		REG_CHUNK_Y = 2'd1,
		REG_CHUNK_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [FACE_W-1:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} pos_t;

	// Unit offset {x,y,z} of one corner of a face. Each row packs the four
	// corners of a face with corner 0 in the low bits.
	function automatic logic [2:0] corner_offset(input face_t face,
			input logic [CORNER_W-1:0] corner);
		logic [3*CORNERS-1:0] row;
		case (face)
			FACE_PX: row = {3'b101, 3'b111, 3'b110, 3'b100};
			FACE_NX: row = {3'b000, 3'b010, 3'b011, 3'b001};
			FACE_PY: row = {3'b110, 3'b111, 3'b011, 3'b010};
			FACE_NY: row = {3'b101, 3'b100, 3'b000, 3'b001};
			FACE_PZ: row = {3'b011, 3'b111, 3'b101, 3'b001};
			FACE_NZ: row = {3'b110, 3'b010, 3'b000, 3'b100};
			default: row = '0;
		endcase
		return row[3*corner +: 3];
	endfunction

endpackage

// File: design/vfcm_if.sv
interface vfcm_voxel_if import vfcm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LOCAL_W-1:0]  local_x;
	logic [LOCAL_W-1:0]  local_y;
	logic [LOCAL_W-1:0]  local_z;
	logic                block_solid;
	logic [NUM_FACES-1:0] neighbor_blocked;
	logic [COLOUR_W-1:0] colour_red;
	logic [COLOUR_W-1:0] colour_green;
	logic [COLOUR_W-1:0] colour_blue;
	logic                chunk_start;

	modport source (output valid, local_x, local_y, local_z, block_solid, neighbor_blocked,
		colour_red, colour_green, colour_blue, chunk_start, input ready);
	modport sink (input valid, local_x, local_y, local_z, block_solid, neighbor_blocked,
		colour_red, colour_green, colour_blue, chunk_start, output ready);
endinterface

interface vfcm_vertex_if import vfcm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [POS_W-1:0]    pos_z;
	logic [FACE_W-1:0]   face_code;
	logic [COLOUR_W-1:0] out_red;
	logic [COLOUR_W-1:0] out_green;
	logic [COLOUR_W-1:0] out_blue;
	logic [VNUM_W-1:0]   vertex_number;
	logic                last_of_voxel;

	modport source (output valid, pos_x, pos_y, pos_z, face_code, out_red, out_green,
		out_blue, vertex_number, last_of_voxel, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, face_code, out_red, out_green,
		out_blue, vertex_number, last_of_voxel, output ready);
endinterface

// File: design/vfcm_face_lane.sv
// One face lane: world position of the selected corner of a fixed face.
module vfcm_face_lane import vfcm_pkg::*; (
	input  face_t                face,
	input  logic [CORNER_W-1:0]  corner,
	input  pos_t                 base,
	output pos_t                 vertex
);

	logic [2:0] offset;

	always_comb begin
		offset   = corner_offset(face, corner);
		vertex.x = base.x + POS_W'(offset[2]);
		vertex.y = base.y + POS_W'(offset[1]);
		vertex.z = base.z + POS_W'(offset[0]);
	end

endmodule

// File: design/voxel_face_culling_mesher.sv
// Channel   Direction  Transaction
// --------  ---------  ---------------------------------------------------
// voxel     in         one voxel: local position, solid flag, neighbor
//                      flags, color, chunk start
// vertex    out        one vertex: world position, face, color, index, last
// cfg_*     in         register write, index 0..2 = chunk_x, chunk_y, chunk_z
//
// A voxel with n exposed faces yields 4*n vertices, one vertex per cycle through the vertex
// output register while the vertex channel does not stall; a voxel with no exposed face
// never enters the emitter. The first vertex passes the emitter stage and then the vertex
// output register before it is offered.
// arst_n clears the chunk registers, the vertex counter and all valid flags.
// A stall on the vertex channel holds the output register and the emitter; the
// next voxel is taken in the cycle in which the last vertex of the current one moves on.
module voxel_face_culling_mesher import vfcm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vfcm_voxel_if.sink            voxel,
	vfcm_vertex_if.source         vertex
);

	// Chunk base registers; the user must write them only while idle, the block does not enforce it.
	logic [CHUNK_W-1:0] chunk_x_q;
	logic [CHUNK_W-1:0] chunk_y_q;
	logic [CHUNK_W-1:0] chunk_z_q;

	// Emitter stage: the voxel currently being expanded into vertices.
	// mask_s1 holds the faces still to emit; the lowest set bit is the current face.
	logic                 vld_s1;
	logic [NUM_FACES-1:0] mask_s1;
	logic [CORNER_W-1:0]  corner_s1;
	pos_t                 base_s1;
	logic [COLOUR_W-1:0]  red_s1;
	logic [COLOUR_W-1:0]  green_s1;
	logic [COLOUR_W-1:0]  blue_s1;

	// Running vertex index within the chunk.
	logic [VNUM_W-1:0] counter_q;

	// Vertex output register.
	logic                out_vld_q;
	pos_t                out_pos_q;
	face_t               out_face_q;
	logic [COLOUR_W-1:0] out_red_q;
	logic [COLOUR_W-1:0] out_green_q;
	logic [COLOUR_W-1:0] out_blue_q;
	logic [VNUM_W-1:0]   out_vnum_q;
	logic                out_last_q;

	logic                 accept;
	logic                 emit;
	logic                 last_vtx;
	logic [NUM_FACES-1:0] sel_onehot;
	logic [NUM_FACES-1:0] rest_mask;
	logic [NUM_FACES-1:0] new_mask;
	face_t                face_sel;
	pos_t                 lane_pos [NUM_FACES];
	pos_t                 merged_pos;
	pos_t                 new_base;

	// Configuration writes. Indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_x_q <= '0;
			chunk_y_q <= '0;
			chunk_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHUNK_X: chunk_x_q <= cfg_data;
				REG_CHUNK_Y: chunk_y_q <= cfg_data;
				REG_CHUNK_Z: chunk_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// World base of the incoming voxel: chunk index scaled by the chunk edge plus
	// the local position. Sums wrap at the position width.
	always_comb begin
		new_base.x = POS_W'(chunk_x_q) * POS_W'(CHUNK_EDGE) + POS_W'(voxel.local_x);
		new_base.y = POS_W'(chunk_y_q) * POS_W'(CHUNK_EDGE) + POS_W'(voxel.local_y);
		new_base.z = POS_W'(chunk_z_q) * POS_W'(CHUNK_EDGE) + POS_W'(voxel.local_z);
		new_mask   = voxel.block_solid ? ~voxel.neighbor_blocked : '0;
	end

	// Pick the lowest pending face.
	always_comb begin
		face_sel = FACE_PX;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				face_sel = face_t'(FACE_W'(i));
			end
		end
		sel_onehot = mask_s1 & (~mask_s1 + NUM_FACES'(1));
		rest_mask  = mask_s1 & ~sel_onehot;
	end

	// Every face has its own lane that works out the current corner; the merge
	// keeps the lane of the face being emitted.
	for (genvar f = 0; f < NUM_FACES; f++) begin : g_lane
		vfcm_face_lane u_lane (
			.face   (face_t'(FACE_W'(f))),
			.corner (corner_s1),
			.base   (base_s1),
			.vertex (lane_pos[f])
		);
	end

	always_comb begin
		merged_pos = '0;
		for (int i = 0; i < NUM_FACES; i++) begin
			merged_pos = merged_pos | (lane_pos[i] & {($bits(pos_t)){sel_onehot[i]}});
		end
	end

	// A vertex moves into the output register whenever that register is free or
	// being emptied. The next voxel is taken once the last vertex leaves the emitter.
	assign emit        = vld_s1 && (!out_vld_q || vertex.ready);
	assign last_vtx    = (corner_s1 == CORNER_W'(CORNERS - 1)) && (rest_mask == '0);
	assign voxel.ready = !vld_s1 || (emit && last_vtx);
	assign accept      = voxel.valid && voxel.ready;

	// Emitter control. A voxel with no exposed face never occupies the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			mask_s1   <= '0;
			corner_s1 <= '0;
		end else if (accept) begin
			vld_s1    <= |new_mask;
			mask_s1   <= new_mask;
			corner_s1 <= '0;
		end else if (emit) begin
			corner_s1 <= corner_s1 + CORNER_W'(1);
			if (corner_s1 == CORNER_W'(CORNERS - 1)) begin
				mask_s1 <= rest_mask;
				if (rest_mask == '0) begin
					vld_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1  <= new_base;
			red_s1   <= voxel.colour_red;
			green_s1 <= voxel.colour_green;
			blue_s1  <= voxel.colour_blue;
		end
	end

	// The counter is cleared when a chunk start voxel is taken, whether or not it
	// emits anything. Its vertices come later, so the clear wins over a count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (accept && voxel.chunk_start) begin
			counter_q <= '0;
		end else if (emit) begin
			counter_q <= counter_q + VNUM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (vertex.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pos_q   <= merged_pos;
			out_face_q  <= face_sel;
			out_red_q   <= red_s1;
			out_green_q <= green_s1;
			out_blue_q  <= blue_s1;
			out_vnum_q  <= counter_q;
			out_last_q  <= last_vtx;
		end
	end

	assign vertex.valid         = out_vld_q;
	assign vertex.pos_x         = out_pos_q.x;
	assign vertex.pos_y         = out_pos_q.y;
	assign vertex.pos_z         = out_pos_q.z;
	assign vertex.face_code     = out_face_q;
	assign vertex.out_red       = out_red_q;
	assign vertex.out_green     = out_green_q;
	assign vertex.out_blue      = out_blue_q;
	assign vertex.vertex_number = out_vnum_q;
	assign vertex.last_of_voxel = out_last_q;

endmodule

// File: design/vfcm_checker.sv
`include "voxel_face_culling_mesher_defines.svh"

module vfcm_checker import vfcm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [POS_W-1:0]    out_pos_x,
	input logic [FACE_W-1:0]   out_face_code,
	input logic [COLOUR_W-1:0] out_red,
	input logic [COLOUR_W-1:0] out_green,
	input logic [COLOUR_W-1:0] out_blue,
	input logic [VNUM_W-1:0]   out_vertex_number,
	input logic                out_last
);

	logic                  stalled;
	logic                  mid;
	logic [3*COLOUR_W-1:0] colour;
	logic [VNUM_W-1:0]     number_next;

	assign stalled     = out_valid && !out_ready;
	assign mid         = out_valid && out_ready && !out_last;
	assign colour      = {out_red, out_green, out_blue};
	assign number_next = out_vertex_number + VNUM_W'(1);

	// A stalled vertex stays put.
	`VFCM_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable({out_vertex_number, out_pos_x}))

	// The vertices of one voxel follow without a gap once the sink takes them.
	`VFCM_ASSERT_NXT(a_voxel_continues, mid, out_valid)

	// Within one voxel the index steps by one.
	`VFCM_ASSERT_NXT(a_number_steps, mid, out_vertex_number == $past(number_next))

	// Within one voxel the color does not change.
	`VFCM_ASSERT_NXT(a_colour_kept, mid, $stable(colour))

	// Only the six face codes appear.
	`VFCM_ASSERT_IMP(a_face_legal, out_valid, out_face_code <= FACE_NZ)

endmodule

bind voxel_face_culling_mesher vfcm_checker u_vfcm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (vertex.valid),
	.out_ready         (vertex.ready),
	.out_pos_x         (vertex.pos_x),
	.out_face_code     (vertex.face_code),
	.out_red           (vertex.out_red),
	.out_green         (vertex.out_green),
	.out_blue          (vertex.out_blue),
	.out_vertex_number (vertex.vertex_number),
	.out_last          (vertex.last_of_voxel)
);
